// ===== sv/tpry_pkg.sv =====
`timescale 1ns / 1ps
// Package for the tile pad RGB to YUV block: types, codes and coefficients.
// Used by the controller, the datapath and the top level; depends on nothing.
package tpry_pkg;

  localparam int TILE_SIZE_DEF = 64;
  localparam int POS_W         = 6;
  localparam int CFG_W         = 7;

  localparam int signed C_Y_R = 19595;
  localparam int signed C_Y_G = 38470;
  localparam int signed C_Y_B = 7471;
  localparam int signed C_U_R = -11071;
  localparam int signed C_U_G = -21736;
  localparam int signed C_U_B = 32807;
  localparam int signed C_V_R = 32756;
  localparam int signed C_V_G = -27429;
  localparam int signed C_V_B = -5327;
  localparam int CHROMA_OFS   = 128;
  localparam int FRAC_BITS    = 16;

  localparam int PROD_W = 25;
  localparam int SUM_W  = 27;

  typedef enum logic [1:0] {
    BO_BGRA = 2'd0,
    BO_RGBA = 2'd1,
    BO_BGR  = 2'd2,
    BO_RGB  = 2'd3
  } byte_order_t;

  typedef enum logic [1:0] {
    CFG_BYTE_ORDER   = 2'd0,
    CFG_VALID_WIDTH  = 2'd1,
    CFG_VALID_HEIGHT = 2'd2
  } cfg_index_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CONV1,
    ST_CONV2,
    ST_SRC_SEND,
    ST_PAD_READ,
    ST_PAD_SEND,
    ST_REJECT
  } ctrl_state_t;

  typedef enum logic [1:0] {
    SEL_SRC,
    SEL_PAD,
    SEL_REJ
  } out_sel_t;

  typedef struct packed {
    logic             capture;
    logic             out_load;
    out_sel_t         out_sel;
    logic [POS_W-1:0] column;
    logic [POS_W-1:0] row;
    logic             run_end;
    logic             tile_end;
    logic             mem_we;
    logic             rd_en;
    logic [POS_W-1:0] rd_addr;
  } dp_cmd_t;

  typedef struct packed {
    logic out_free;
  } dp_status_t;

endpackage

// ===== sv/tpry_in_if.sv =====
`timescale 1ns / 1ps
// Input channel of the tile pad RGB to YUV block: one source pixel or pad-row request.
// Stand-alone; no package needed.
interface tpry_in_if;
  logic        valid;
  logic        ready;
  logic        action;
  logic [31:0] pixel_word;

  modport source (output valid, action, pixel_word, input ready);
  modport sink (input valid, action, pixel_word, output ready);
endinterface

// ===== sv/tpry_out_if.sv =====
`timescale 1ns / 1ps
// Result channel of the tile pad RGB to YUV block: one converted tile pixel.
// Stand-alone; no package needed.
interface tpry_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] luma;
  logic [7:0] blue_diff;
  logic [7:0] red_diff;
  logic [7:0] alpha;
  logic [5:0] column;
  logic [5:0] row;
  logic       run_end;
  logic       tile_end;
  logic       rejected;

  modport source (output valid, luma, blue_diff, red_diff, alpha, column, row,
                  run_end, tile_end, rejected, input ready);
  modport sink (input valid, luma, blue_diff, red_diff, alpha, column, row,
                run_end, tile_end, rejected, output ready);
endinterface

// ===== sv/tpry_ctrl.sv =====
`timescale 1ns / 1ps
// Controller of the tile pad RGB to YUV block: sequencing, tile position counters.
// Depends on tpry_pkg.
module tpry_ctrl #(
  parameter int TILE_SIZE = tpry_pkg::TILE_SIZE_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  input  logic                       in_action,
  output logic                       in_ready,
  input  logic [tpry_pkg::CFG_W-1:0] valid_width,
  input  logic [tpry_pkg::CFG_W-1:0] valid_height,
  output tpry_pkg::dp_cmd_t          cmd,
  input  tpry_pkg::dp_status_t       status
);
  import tpry_pkg::*;

  localparam int CW = $clog2(TILE_SIZE);
  localparam logic [CW-1:0]    LAST     = CW'(TILE_SIZE - 1);
  localparam logic [CFG_W-1:0] TILE_CFG = CFG_W'(TILE_SIZE);

  ctrl_state_t    state_r, state_nxt;
  logic [CW-1:0]  col_r, col_nxt;
  logic [CW-1:0]  row_r, row_nxt;
  logic [CW-1:0]  cnt_r, cnt_nxt;
  logic [CW-1:0]  end_r, end_nxt;
  logic           done_r, done_nxt;
  logic [CFG_W-1:0] eff_w, eff_h;
  logic           ok;
  logic           row_fills;
  logic [CW-1:0]  row_inc;

  always_comb begin
    if (valid_width == '0) begin
      eff_w = CFG_W'(1);
    end else if (valid_width > TILE_CFG) begin
      eff_w = TILE_CFG;
    end else begin
      eff_w = valid_width;
    end
    if (valid_height == '0) begin
      eff_h = CFG_W'(1);
    end else if (valid_height > TILE_CFG) begin
      eff_h = TILE_CFG;
    end else begin
      eff_h = valid_height;
    end
  end

  assign row_inc   = (row_r == LAST) ? '0 : row_r + CW'(1);
  assign row_fills = (CFG_W'(col_r) + CFG_W'(1)) >= eff_w;

  always_comb begin
    if (!in_action) begin
      ok = (col_r != '0) || (CFG_W'(row_r) < eff_h);
    end else begin
      ok = (col_r == '0) && (CFG_W'(row_r) >= eff_h);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      col_r   <= '0;
      row_r   <= '0;
      cnt_r   <= '0;
      end_r   <= '0;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      col_r   <= col_nxt;
      row_r   <= row_nxt;
      cnt_r   <= cnt_nxt;
      end_r   <= end_nxt;
      done_r  <= done_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    col_nxt   = col_r;
    row_nxt   = row_r;
    cnt_nxt   = cnt_r;
    end_nxt   = end_r;
    done_nxt  = done_r;
    in_ready  = 1'b0;
    cmd       = '0;
    cmd.out_sel = SEL_REJ;

    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          if (!ok) begin
            state_nxt = ST_REJECT;
          end else if (in_action) begin
            cnt_nxt   = '0;
            state_nxt = ST_PAD_READ;
          end else begin
            cnt_nxt   = col_r;
            done_nxt  = row_fills;
            end_nxt   = row_fills ? LAST : col_r;
            state_nxt = ST_CONV1;
          end
        end
      end
      ST_CONV1: begin
        state_nxt = ST_CONV2;
      end
      ST_CONV2: begin
        state_nxt = ST_SRC_SEND;
      end
      ST_SRC_SEND: begin
        cmd.out_sel  = SEL_SRC;
        cmd.column   = POS_W'(cnt_r);
        cmd.row      = POS_W'(row_r);
        cmd.run_end  = (cnt_r == end_r);
        cmd.tile_end = (cnt_r == LAST) && (row_r == LAST);
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          cmd.mem_we   = 1'b1;
          if (cnt_r == end_r) begin
            state_nxt = ST_IDLE;
            if (done_r) begin
              col_nxt = '0;
              row_nxt = row_inc;
            end else begin
              col_nxt = col_r + CW'(1);
            end
          end else begin
            cnt_nxt = cnt_r + CW'(1);
          end
        end
      end
      ST_PAD_READ: begin
        cmd.rd_en   = 1'b1;
        cmd.rd_addr = '0;
        state_nxt   = ST_PAD_SEND;
      end
      ST_PAD_SEND: begin
        cmd.out_sel  = SEL_PAD;
        cmd.column   = POS_W'(cnt_r);
        cmd.row      = POS_W'(row_r);
        cmd.run_end  = (cnt_r == LAST);
        cmd.tile_end = (cnt_r == LAST) && (row_r == LAST);
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          if (cnt_r == LAST) begin
            state_nxt = ST_IDLE;
            row_nxt   = row_inc;
          end else begin
            cnt_nxt     = cnt_r + CW'(1);
            cmd.rd_en   = 1'b1;
            cmd.rd_addr = POS_W'(cnt_r + CW'(1));
          end
        end
      end
      ST_REJECT: begin
        cmd.run_end = 1'b1;
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== sv/tpry_datapath.sv =====
`timescale 1ns / 1ps
// Datapath of the tile pad RGB to YUV block: colour conversion pipeline, line store
// and result register. Depends on tpry_pkg.
module tpry_datapath #(
  parameter int TILE_SIZE = tpry_pkg::TILE_SIZE_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic [31:0]          in_pixel_word,
  input  tpry_pkg::byte_order_t byte_order,
  input  tpry_pkg::dp_cmd_t    cmd,
  output tpry_pkg::dp_status_t status,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [7:0]           out_luma,
  output logic [7:0]           out_blue_diff,
  output logic [7:0]           out_red_diff,
  output logic [7:0]           out_alpha,
  output logic [5:0]           out_column,
  output logic [5:0]           out_row,
  output logic                 out_run_end,
  output logic                 out_tile_end,
  output logic                 out_rejected
);
  import tpry_pkg::*;

  localparam int CW = $clog2(TILE_SIZE);
  localparam logic signed [SUM_W-1:0] OFS = SUM_W'(CHROMA_OFS <<< FRAC_BITS);

  logic [31:0] word_r;
  logic signed [PROD_W-1:0] prod_r [9];
  logic signed [PROD_W-1:0] prod_nxt [9];
  logic [7:0]  alpha_r, alpha_nxt;
  logic [31:0] pix_r, pix_nxt;
  logic [31:0] mem [TILE_SIZE];
  logic [31:0] rd_data_r;
  logic        out_valid_r;
  logic [31:0] out_pix_r;
  logic [5:0]  out_col_r, out_row_r;
  logic        out_run_end_r, out_tile_end_r, out_rej_r;
  logic signed [8:0] r, g, b;
  logic signed [SUM_W-1:0] sum_y, sum_u, sum_v;
  logic [31:0] sel_pix;

  function automatic logic [7:0] clamp8(input logic signed [SUM_W-1:0] s);
    logic [SUM_W-FRAC_BITS-1:0] q;
    q = s[SUM_W-1:FRAC_BITS];
    return (q > (SUM_W-FRAC_BITS)'(255)) ? 8'hFF : q[7:0];
  endfunction

  always_comb begin
    g = $signed({1'b0, word_r[15:8]});
    if (byte_order inside {BO_BGRA, BO_BGR}) begin
      b = $signed({1'b0, word_r[7:0]});
      r = $signed({1'b0, word_r[23:16]});
    end else begin
      r = $signed({1'b0, word_r[7:0]});
      b = $signed({1'b0, word_r[23:16]});
    end
    alpha_nxt = (byte_order inside {BO_BGR, BO_RGB}) ? 8'd0 : word_r[31:24];
    prod_nxt[0] = PROD_W'(r * C_Y_R);
    prod_nxt[1] = PROD_W'(g * C_Y_G);
    prod_nxt[2] = PROD_W'(b * C_Y_B);
    prod_nxt[3] = PROD_W'(r * C_U_R);
    prod_nxt[4] = PROD_W'(g * C_U_G);
    prod_nxt[5] = PROD_W'(b * C_U_B);
    prod_nxt[6] = PROD_W'(r * C_V_R);
    prod_nxt[7] = PROD_W'(g * C_V_G);
    prod_nxt[8] = PROD_W'(b * C_V_B);
  end

  always_comb begin
    sum_y = SUM_W'(prod_r[0]) + SUM_W'(prod_r[1]) + SUM_W'(prod_r[2]);
    sum_u = SUM_W'(prod_r[3]) + SUM_W'(prod_r[4]) + SUM_W'(prod_r[5]) + OFS;
    sum_v = SUM_W'(prod_r[6]) + SUM_W'(prod_r[7]) + SUM_W'(prod_r[8]) + OFS;
    pix_nxt = {alpha_r, clamp8(sum_v), clamp8(sum_u), clamp8(sum_y)};
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      word_r <= in_pixel_word;
    end
    prod_r  <= prod_nxt;
    alpha_r <= alpha_nxt;
    pix_r   <= pix_nxt;
  end

  always_ff @(posedge clk) begin
    if (cmd.mem_we) begin
      mem[cmd.column[CW-1:0]] <= pix_r;
    end
    if (cmd.rd_en) begin
      rd_data_r <= mem[cmd.rd_addr[CW-1:0]];
    end
  end

  always_comb begin
    case (cmd.out_sel)
      SEL_SRC: sel_pix = pix_r;
      SEL_PAD: sel_pix = rd_data_r;
      default: sel_pix = '0;
    endcase
  end

  assign status.out_free = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_pix_r      <= sel_pix;
      out_col_r      <= cmd.column;
      out_row_r      <= cmd.row;
      out_run_end_r  <= cmd.run_end;
      out_tile_end_r <= cmd.tile_end;
      out_rej_r      <= (cmd.out_sel == SEL_REJ);
    end
  end

  assign out_valid     = out_valid_r;
  assign out_luma      = out_pix_r[7:0];
  assign out_blue_diff = out_pix_r[15:8];
  assign out_red_diff  = out_pix_r[23:16];
  assign out_alpha     = out_pix_r[31:24];
  assign out_column    = out_col_r;
  assign out_row       = out_row_r;
  assign out_run_end   = out_run_end_r;
  assign out_tile_end  = out_tile_end_r;
  assign out_rejected  = out_rej_r;

endmodule

// ===== sv/tile_pad_rgb_to_yuv.sv =====
`timescale 1ns / 1ps
// Tile pad RGB to YUV: top level. A source pixel request passes the input word, product and
// pixel registers before its first result loads, then loads one result a cycle while the
// result register is free; a pad-row request first reads the line store, a rejected one loads
// a single rejected result. The rate is set by the controller, which handles one request at a
// time, and by the line store's single read port. Synchronous active-low reset clears the
// counters and out_valid, restores the default configuration; the line store is not cleared.
module tile_pad_rgb_to_yuv #(
  parameter int TILE_SIZE = tpry_pkg::TILE_SIZE_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  tpry_in_if.sink                    in_chan,
  tpry_out_if.source                 out_chan,
  input  logic                       cfg_we,
  input  logic [1:0]                 cfg_index,
  input  logic [tpry_pkg::CFG_W-1:0] cfg_wdata
);
  import tpry_pkg::*;

  byte_order_t      byte_order_r;
  logic [CFG_W-1:0] valid_width_r;
  logic [CFG_W-1:0] valid_height_r;
  dp_cmd_t          cmd;
  dp_status_t       status;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_order_r   <= BO_BGRA;
      valid_width_r  <= CFG_W'(64);
      valid_height_r <= CFG_W'(64);
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_BYTE_ORDER:   byte_order_r   <= byte_order_t'(cfg_wdata[1:0]);
        CFG_VALID_WIDTH:  valid_width_r  <= cfg_wdata;
        CFG_VALID_HEIGHT: valid_height_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  tpry_ctrl #(
    .TILE_SIZE(TILE_SIZE)
  ) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_chan.valid),
    .in_action   (in_chan.action),
    .in_ready    (in_chan.ready),
    .valid_width (valid_width_r),
    .valid_height(valid_height_r),
    .cmd         (cmd),
    .status      (status)
  );

  tpry_datapath #(
    .TILE_SIZE(TILE_SIZE)
  ) u_datapath (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_pixel_word(in_chan.pixel_word),
    .byte_order   (byte_order_r),
    .cmd          (cmd),
    .status       (status),
    .out_valid    (out_chan.valid),
    .out_ready    (out_chan.ready),
    .out_luma     (out_chan.luma),
    .out_blue_diff(out_chan.blue_diff),
    .out_red_diff (out_chan.red_diff),
    .out_alpha    (out_chan.alpha),
    .out_column   (out_chan.column),
    .out_row      (out_chan.row),
    .out_run_end  (out_chan.run_end),
    .out_tile_end (out_chan.tile_end),
    .out_rejected (out_chan.rejected)
  );

endmodule
